### hdl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define DMPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define DMPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/dmpc_pkg.sv
// Package: sizes, request codes and line entry type of the page cache.
package dmpc_pkg;

  localparam int ENTRIES = 64;
  localparam int SWAPS   = 8;

  localparam int LINE_W = 6;
  localparam int SLOT_W = 3;
  localparam int PAGE_W = 7;
  localparam int TAG_W  = 64;
  localparam int REQ_W  = 3;

  localparam logic [REQ_W-1:0] REQ_LOOKUP  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CHECK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_GETBUF  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INSTALL = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

  typedef logic [LINE_W-1:0] line_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [TAG_W-1:0]  tag_t;

  // One cache line: tag and owned data page.
  typedef struct packed {
    tag_t  tag;
    page_t page;
  } line_entry_t;

endpackage

### hdl/dmpc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dmpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read of the written address returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/direct_mapped_page_cache_swap.sv
// Top level: direct-mapped page cache with directory tags and swap pages.
//
//  channel   direction  handshake              fields
//  request   in         start, busy            req_type, lpa, line_index, swap_slot
//  result    out        done (one-cycle pulse) hit, page_id, slot_used, home_line
//
// A request is taken when start is high and busy is low. The line and directory
// RAMs are read in the accept cycle; the next cycle modifies and writes back,
// and the result shows with done in the cycle after. busy holds for that one
// modify cycle, so no new request is taken before it ends: the registered RAM read sets this.
// Reset clears the per-line valid bits at once; no clearing pass is needed.
// The receiver cannot stall the result.
module direct_mapped_page_cache_swap (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             req_type,
  input  logic [63:0]            lpa,
  input  dmpc_pkg::line_t        line_index,
  input  dmpc_pkg::slot_t        swap_slot,
  output logic                   done,
  output logic                   hit,
  output dmpc_pkg::page_t        page_id,
  output dmpc_pkg::slot_t        slot_used,
  output dmpc_pkg::line_t        home_line
);
  import dmpc_pkg::*;

  // Request held during the modify cycle.
  logic             s1_valid;
  logic [REQ_W-1:0] s1_req;
  tag_t             s1_lpa;
  line_t            s1_line;
  slot_t            s1_slot;

  // Per-line valid bits: an invalid entry reads as its reset value.
  logic [ENTRIES-1:0] line_vld;
  logic [ENTRIES-1:0] dir_vld;

  // Swap table and round-robin pointer.
  page_t swap_page [SWAPS];
  slot_t swap_ptr;

  line_entry_t line_rdata, line_cur, line_wdata;
  tag_t        dir_rdata, dir_cur;
  logic        line_we, dir_we, swap_we, ptr_adv;
  page_t       swap_wdata;
  slot_t       swap_waddr;
  logic        hit_next;
  page_t       page_next;
  slot_t       used_next;

  logic accept;
  assign accept = start && !busy;
  assign busy   = s1_valid;

  dmpc_ram #(.WIDTH($bits(line_entry_t)), .DEPTH(ENTRIES)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_line),
    .wdata (line_wdata),
    .raddr (line_index),
    .rdata (line_rdata)
  );

  dmpc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (s1_line),
    .wdata (s1_lpa),
    .raddr (line_index),
    .rdata (dir_rdata)
  );

  // Capture the request at accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_req  <= req_type;
      s1_lpa  <= lpa;
      s1_line <= line_index;
      s1_slot <= swap_slot;
    end
  end

  // Substitute reset values for lines never written.
  always_comb begin
    if (line_vld[s1_line]) begin
      line_cur = line_rdata;
    end else begin
      line_cur.tag  = '0;
      line_cur.page = PAGE_W'(SWAPS) + PAGE_W'(s1_line);
    end
    dir_cur = dir_vld[s1_line] ? dir_rdata : '0;
  end

  // Decode the request and form write-backs and result.
  always_comb begin
    line_we    = 1'b0;
    dir_we     = 1'b0;
    swap_we    = 1'b0;
    ptr_adv    = 1'b0;
    swap_waddr = s1_slot;
    swap_wdata = line_cur.page;
    line_wdata.tag  = s1_lpa;
    line_wdata.page = swap_page[s1_slot];
    hit_next   = 1'b0;
    page_next  = '0;
    used_next  = '0;
    unique case (s1_req)
      REQ_LOOKUP: begin
        hit_next = (line_cur.tag == s1_lpa);
      end
      REQ_CHECK: begin
        hit_next = (dir_cur == s1_lpa);
        dir_we   = s1_valid && !hit_next;
      end
      REQ_GETBUF: begin
        used_next = swap_ptr;
        page_next = swap_page[swap_ptr];
        ptr_adv   = s1_valid;
      end
      REQ_INSTALL: begin
        page_next = swap_page[s1_slot];
        line_we   = s1_valid;
        swap_we   = s1_valid;
      end
      REQ_READ: begin
        page_next = line_cur.page;
      end
      default: begin
      end
    endcase
  end

  // Update valid bits, swap table and pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_vld <= '0;
      dir_vld  <= '0;
      swap_ptr <= '0;
      for (int i = 0; i < SWAPS; i++) begin
        swap_page[i] <= PAGE_W'(i);
      end
    end else begin
      if (line_we) begin
        line_vld[s1_line] <= 1'b1;
      end
      if (dir_we) begin
        dir_vld[s1_line] <= 1'b1;
      end
      if (swap_we) begin
        swap_page[swap_waddr] <= swap_wdata;
      end
      if (ptr_adv) begin
        swap_ptr <= (swap_ptr == SLOT_W'(SWAPS - 1)) ? '0 : swap_ptr + 1'b1;
      end
    end
  end

  // Register the result and pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    if (s1_valid) begin
      hit       <= hit_next;
      page_id   <= page_next;
      slot_used <= used_next;
      home_line <= s1_lpa[LINE_W-1:0];
    end
  end

endmodule

### hdl/dmpc_checker.sv
// Port-level checker for the page cache, bound to the top level.
`include "assert_macros.svh"

module dmpc_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic [2:0]             req_type,
  input logic                   done,
  input logic                   hit,
  input dmpc_pkg::page_t        page_id
);
  import dmpc_pkg::*;

  // An accepted request holds off the next one for its modify cycle.
  `DMPC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy not raised after accept")

  // Every result follows an accept, through the s1_valid and done registers.
  `DMPC_ASSERT_NOW(a_done_origin, clk, rst, done, $past(start && !busy, 2), "result without request")

  // A hit only comes from a lookup or a tag check.
  `DMPC_ASSERT_NOW(a_hit_kind, clk, rst, done && hit,
    $past(req_type, 2) == REQ_LOOKUP || $past(req_type, 2) == REQ_CHECK,
    "hit on a request that compares no tag")

  // Page ids stay within the pool of line and swap pages.
  `DMPC_ASSERT_NOW(a_page_range, clk, rst, done, page_id < PAGE_W'(ENTRIES + SWAPS),
    "page id outside the page pool")

endmodule

bind direct_mapped_page_cache_swap dmpc_checker u_dmpc_checker (.*);
